/* hw/rtl/kt_pkg.sv */
// Shared types and constants for the Kendall tau-b merge-count engine.
package kt_pkg;

    // Fixed field widths on the stream ports.
    localparam int IN_KEY_W   = 32;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 96;
    localparam int TAU_W      = 32;
    localparam int SCORE_W    = 20;
    localparam int UNTIED_W   = 19;
    localparam int STATUS_W   = 2;

    // Tau is found from floor(S^2 * 2^62 / prod), then a square root.
    localparam int FRAC_SHIFT = 62;
    localparam int QUO_W      = 64;
    localparam int MAG_W      = 31;
    localparam logic [MAG_W-1:0] Q30_ONE = 31'h4000_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_UNDEF    = 2'd1,
        ST_ORDER    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PSTART,
        S_BLK,
        S_LDL,
        S_LDR,
        S_CMP,
        S_FILL,
        S_SCAN_RD,
        S_SCAN_ACC,
        S_MUL1,
        S_SCORE,
        S_MUL2,
        S_MUL3,
        S_ROOT_GO,
        S_ROOT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_SQRT,
        R_DONE
    } root_state_t;

    // Result of the divide and square-root unit.
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] mag;
    } root_res_t;

endpackage

/* hw/rtl/kt_ram.sv */
// Simple dual-port memory with one write port and a registered read port.
module kt_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/kt_root_div.sv */
// Iterative unit: restoring division of S^2 * 2^62 by the pair product,
// then a bit-pair square root, giving the rounded tau magnitude.
module kt_root_div #(
    parameter int PW = 22
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2*PW-1:0]      num,
    input  logic [2*PW-1:0]      den,
    output kt_pkg::root_res_t    res
);
    import kt_pkg::*;

    localparam int XW    = 2 * PW + FRAC_SHIFT;
    localparam int RW    = 2 * PW + 1;
    localparam int CNT_W = $clog2(XW + 1);

    root_state_t       state_reg, state_next;
    logic [XW-1:0]     dvd_reg, dvd_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [2*PW-1:0]   den_reg, den_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [QUO_W-1:0]  sq_num_reg, sq_num_next;
    logic [QUO_W-1:0]  sq_res_reg, sq_res_next;
    logic [QUO_W-1:0]  sq_bit_reg, sq_bit_next;

    logic [RW-1:0]     rem_sh;
    logic              q_bit;
    logic [QUO_W-1:0]  trial;
    logic [QUO_W:0]    res_p1;
    logic [QUO_W-1:0]  half;

    // One quotient bit per cycle.
    assign rem_sh = {rem_reg[RW-2:0], dvd_reg[XW-1]};
    assign q_bit  = (rem_sh >= {1'b0, den_reg});
    assign trial  = sq_res_reg + sq_bit_reg;

    // Halve the root, rounding to nearest, and clamp to one.
    assign res_p1 = {1'b0, sq_res_reg} + {{QUO_W{1'b0}}, 1'b1};
    assign half   = res_p1[QUO_W:1];

    always_comb
    begin
        res.done = (state_reg == R_DONE);
        if (half > {{(QUO_W-MAG_W){1'b0}}, Q30_ONE})
        begin
            res.mag = Q30_ONE;
        end
        else
        begin
            res.mag = half[MAG_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    state_next = R_DIV;
                end
            end
            R_DIV:
            begin
                if (cnt_reg == CNT_W'(XW - 1))
                begin
                    state_next = R_SQRT;
                end
            end
            R_SQRT:
            begin
                if (sq_bit_reg == {{(QUO_W-1){1'b0}}, 1'b1})
                begin
                    state_next = R_DONE;
                end
            end
            R_DONE:
            begin
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        sq_num_next = sq_num_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        unique case (state_reg)
            R_IDLE:
            begin
                dvd_next = {num, {FRAC_SHIFT{1'b0}}};
                den_next = den;
                rem_next = '0;
                quo_next = '0;
                cnt_next = '0;
            end
            R_DIV:
            begin
                rem_next = q_bit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                dvd_next = {dvd_reg[XW-2:0], 1'b0};
                quo_next = {quo_reg[QUO_W-2:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                sq_num_next = {quo_reg[QUO_W-2:0], q_bit};
                sq_res_next = '0;
                sq_bit_next = {2'b01, {(QUO_W-2){1'b0}}};
            end
            R_SQRT:
            begin
                if (sq_num_reg >= trial)
                begin
                    sq_num_next = sq_num_reg - trial;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
            end
            R_DONE:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        sq_num_reg <= sq_num_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
    end

endmodule

/* hw/rtl/kendall_tau_b_merge_count.sv */
// Top level of the Kendall tau-b engine (merge-count method).
//
// Input stream: one (x, y) key pair per item, x nondecreasing, tlast on the
// final pair of a data set; tready stays high while pairs are loaded into the
// pair memory. After the last pair the block stops taking items and works
// on the set: a bottom-up merge sort of the pairs by (x, y), a scan for x ties
// and joint ties, a second merge sort by y alone that counts inversions, a
// scan for y ties, three products on the shared multiplier, and the divide
// and square-root unit for tau; a set with an undefined ratio stops after the
// first product. Each merge block opens with reads of its two run heads, then
// each item costs a write of the smaller head and one memory read to refill
// the consumed head. The single memory read port paces the merge passes; the
// divider and square root produce one bit per cycle.
// A result is one output item: tau in Q2.30, score, untied pair counts, and
// the status in tuser. Sets with an order or overflow error return at once.
// The result waits in an output register; the block then takes the next set
// while that result is stalled, and only holds a second result back until
// the first is taken. Reset empties the set and drops any pending result.
module kendall_tau_b_merge_count #(
    parameter int MAX_ITEMS = 1024,
    parameter int KEY_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // x_key, y_key
    input  logic [kt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_tlast,
    // tau_q30, score_sum, x_untied_pairs, y_untied_pairs, zero fill
    output logic [kt_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [kt_pkg::STATUS_W-1:0]   m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import kt_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int PW = 2 * CW;
    localparam int SW = PW + 2;
    localparam int KW = KEY_BITS;
    localparam int MW = 2 * KW;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              order_err_reg, order_err_next;
    logic              ovf_err_reg, ovf_err_next;
    logic [KW-1:0]     last_x_reg, last_x_next;
    logic [CW-1:0]     n_reg, n_next;
    logic              src_sel_reg, src_sel_next;
    logic              mode_reg, mode_next;
    logic [CW:0]       w_reg, w_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     l_reg, l_next;
    logic [CW-1:0]     r_reg, r_next;
    logic [CW-1:0]     o_reg, o_next;
    logic [MW-1:0]     head_l_reg, head_l_next;
    logic [MW-1:0]     head_r_reg, head_r_next;
    logic              take_r_reg, take_r_next;
    logic [PW-1:0]     inv_reg, inv_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [MW-1:0]     prev_reg, prev_next;
    logic [CW-1:0]     run_a_reg, run_a_next;
    logic [CW-1:0]     run_b_reg, run_b_next;
    logic [PW-1:0]     m1_reg, m1_next;
    logic [PW-1:0]     m2_reg, m2_next;
    logic [PW-1:0]     m3_reg, m3_next;
    logic [2*PW-1:0]   mul_reg, mul_next;
    logic [2*PW-1:0]   s2_reg, s2_next;
    logic [SW-1:0]     s_reg, s_next;
    logic [PW-1:0]     d1_reg, d1_next;
    logic [PW-1:0]     d2_reg, d2_next;
    status_t           status_reg, status_next;
    logic [TAU_W-1:0]  tau_reg, tau_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [STATUS_W-1:0]  out_user_reg, out_user_next;

    // Input keys, low KEY_BITS bits of each field.
    logic [KW+IN_KEY_W-1:0] x_ext, y_ext;
    logic [KW-1:0]          x_key, y_key;
    logic                   s_acc;
    logic                   order_hit, full;
    logic [CW-1:0]          cnt_inc;

    // Memory ports.
    logic              a_we, b_we;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [MW-1:0]     wr_data, a_rdata, b_rdata, rdata;

    // Merge and scan helpers.
    logic [CW+1:0]     sum_mid, sum_hi;
    logic              l_ok, r_ok, lex_less, y_less, take_r;
    logic [CW-1:0]     l_inc, r_inc, o_inc, k_inc;
    logic              x_eq, y_eq;
    logic [PW-1:0]     mul_a, mul_b;
    logic [PW-1:0]     p_val, d1_val, d2_val, abs_s;
    logic [SW-1:0]     s_val, s_neg;
    logic              root_start;
    root_res_t         root_res;
    logic [PW+UNTIED_W-1:0] d1_ext, d2_ext;
    logic [SW+SCORE_W-1:0]  s_ext;

    assign x_ext = {{KW{1'b0}}, s_tdata[IN_KEY_W-1:0]};
    assign y_ext = {{KW{1'b0}}, s_tdata[2*IN_KEY_W-1:IN_KEY_W]};
    assign x_key = x_ext[KW-1:0];
    assign y_key = y_ext[KW-1:0];

    assign s_tready  = (state_reg == S_LOAD);
    assign s_acc     = s_tvalid && s_tready;
    assign order_hit = (cnt_reg != '0) && ($signed(x_key) < $signed(last_x_reg));
    assign full      = (cnt_reg == CW'(MAX_ITEMS));
    assign cnt_inc   = cnt_reg + 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Two ping-pong buffers hold {x, y} pairs with y in the low half.
    kt_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (MW),
        .ADDR_W(AW)
    ) u_ram_a (
        .clk  (clk),
        .we   (a_we),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(a_rdata)
    );

    kt_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (MW),
        .ADDR_W(AW)
    ) u_ram_b (
        .clk  (clk),
        .we   (b_we),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(b_rdata)
    );

    assign rdata = src_sel_reg ? b_rdata : a_rdata;

    kt_root_div #(
        .PW(PW)
    ) u_root (
        .clk  (clk),
        .rst_n(rst_n),
        .start(root_start),
        .num  (s2_reg),
        .den  (mul_reg),
        .res  (root_res)
    );

    // Merge compare: lexicographic (x, y) for the first sort, y for the second.
    assign l_ok     = (l_reg < mid_reg);
    assign r_ok     = (r_reg < hi_reg);
    assign y_less   = $signed(head_r_reg[KW-1:0]) < $signed(head_l_reg[KW-1:0]);
    assign lex_less = ($signed(head_r_reg[MW-1:KW]) < $signed(head_l_reg[MW-1:KW]))
                   || ((head_r_reg[MW-1:KW] == head_l_reg[MW-1:KW]) && y_less);
    assign take_r   = r_ok && (!l_ok || (mode_reg ? y_less : lex_less));
    assign l_inc    = l_reg + 1'b1;
    assign r_inc    = r_reg + 1'b1;
    assign o_inc    = o_reg + 1'b1;
    assign k_inc    = k_reg + 1'b1;
    assign sum_mid  = {2'b00, lo_reg} + {1'b0, w_reg};
    assign sum_hi   = {2'b00, lo_reg} + {w_reg, 1'b0};

    // Scan compare against the previous pair.
    assign x_eq = (rdata[MW-1:KW] == prev_reg[MW-1:KW]);
    assign y_eq = (rdata[KW-1:0] == prev_reg[KW-1:0]);

    // Score arithmetic from the registered n*(n-1).
    assign p_val  = mul_reg[PW:1];
    assign d1_val = p_val - m1_reg;
    assign d2_val = p_val - m2_reg;
    assign s_val  = {2'b00, p_val} - {2'b00, m1_reg} - {2'b00, m2_reg}
                  + {2'b00, m3_reg} - {1'b0, inv_reg, 1'b0};
    assign s_neg  = '0 - s_reg;
    assign abs_s  = s_reg[SW-1] ? s_neg[PW-1:0] : s_reg[PW-1:0];

    // Shared multiplier operand select.
    always_comb
    begin
        unique case (state_reg)
            S_MUL1:
            begin
                mul_a = {{CW{1'b0}}, n_reg};
                mul_b = {{CW{1'b0}}, n_reg - 1'b1};
            end
            S_MUL2:
            begin
                mul_a = abs_s;
                mul_b = abs_s;
            end
            default:
            begin
                mul_a = d1_reg;
                mul_b = d2_reg;
            end
        endcase
    end

    // Output packing.
    assign d1_ext = {{UNTIED_W{1'b0}}, d1_reg};
    assign d2_ext = {{UNTIED_W{1'b0}}, d2_reg};
    assign s_ext  = {{SCORE_W{s_reg[SW-1]}}, s_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (s_acc && s_tlast)
                begin
                    if (ovf_err_reg || full || order_err_reg || order_hit)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_PSTART;
                    end
                end
            end
            S_PSTART:
            begin
                state_next = (w_reg < {1'b0, n_reg}) ? S_BLK : S_SCAN_RD;
            end
            S_BLK:
            begin
                state_next = S_LDL;
            end
            S_LDL:
            begin
                state_next = S_LDR;
            end
            S_LDR:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (o_inc == hi_reg)
                begin
                    state_next = (hi_reg == n_reg) ? S_PSTART : S_BLK;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                state_next = S_CMP;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_ACC;
            end
            S_SCAN_ACC:
            begin
                if (k_inc == n_reg)
                begin
                    state_next = mode_reg ? S_MUL1 : S_PSTART;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_MUL1:
            begin
                state_next = S_SCORE;
            end
            S_SCORE:
            begin
                if ((n_reg < CW'(2)) || (d1_val == '0) || (d2_val == '0))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                state_next = S_ROOT_GO;
            end
            S_ROOT_GO:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_res.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        cnt_next       = cnt_reg;
        order_err_next = order_err_reg;
        ovf_err_next   = ovf_err_reg;
        last_x_next    = last_x_reg;
        n_next         = n_reg;
        src_sel_next   = src_sel_reg;
        mode_next      = mode_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        o_next         = o_reg;
        head_l_next    = head_l_reg;
        head_r_next    = head_r_reg;
        take_r_next    = take_r_reg;
        inv_next       = inv_reg;
        k_next         = k_reg;
        prev_next      = prev_reg;
        run_a_next     = run_a_reg;
        run_b_next     = run_b_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        m3_next        = m3_reg;
        mul_next       = mul_reg;
        s2_next        = s2_reg;
        s_next         = s_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        status_next    = status_reg;
        tau_next       = tau_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;
        wr_addr        = o_reg[AW-1:0];
        wr_data        = take_r ? head_r_reg : head_l_reg;
        rd_addr        = k_reg[AW-1:0];
        root_start     = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                wr_addr = cnt_reg[AW-1:0];
                wr_data = {x_key, y_key};
                if (s_acc)
                begin
                    a_we           = !full;
                    order_err_next = order_err_reg || order_hit;
                    ovf_err_next   = ovf_err_reg || full;
                    if (!full)
                    begin
                        cnt_next    = cnt_inc;
                        last_x_next = x_key;
                    end
                    if (s_tlast)
                    begin
                        n_next         = full ? cnt_reg : cnt_inc;
                        cnt_next       = '0;
                        order_err_next = 1'b0;
                        ovf_err_next   = 1'b0;
                        src_sel_next   = 1'b0;
                        mode_next      = 1'b0;
                        w_next         = {{CW{1'b0}}, 1'b1};
                        inv_next       = '0;
                        m1_next        = '0;
                        m2_next        = '0;
                        m3_next        = '0;
                        tau_next       = '0;
                        s_next         = '0;
                        d1_next        = '0;
                        d2_next        = '0;
                        if (ovf_err_reg || full)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            status_next = ST_ORDER;
                        end
                    end
                end
            end
            S_PSTART:
            begin
                lo_next    = '0;
                k_next     = '0;
                run_a_next = '0;
                run_b_next = '0;
            end
            S_BLK:
            begin
                mid_next = (sum_mid < {2'b00, n_reg}) ? sum_mid[CW-1:0] : n_reg;
                hi_next  = (sum_hi < {2'b00, n_reg}) ? sum_hi[CW-1:0] : n_reg;
                l_next   = lo_reg;
                r_next   = (sum_mid < {2'b00, n_reg}) ? sum_mid[CW-1:0] : n_reg;
                o_next   = lo_reg;
                rd_addr  = lo_reg[AW-1:0];
            end
            S_LDL:
            begin
                head_l_next = rdata;
                rd_addr     = mid_reg[AW-1:0];
            end
            S_LDR:
            begin
                head_r_next = rdata;
            end
            S_CMP:
            begin
                // Write the smaller head and fetch the next item of its run.
                a_we        = src_sel_reg;
                b_we        = !src_sel_reg;
                take_r_next = take_r;
                o_next      = o_inc;
                if (take_r)
                begin
                    r_next  = r_inc;
                    rd_addr = r_inc[AW-1:0];
                    if (mode_reg && l_ok)
                    begin
                        inv_next = inv_reg + {{CW{1'b0}}, mid_reg - l_reg};
                    end
                end
                else
                begin
                    l_next  = l_inc;
                    rd_addr = l_inc[AW-1:0];
                end
                if (o_inc == hi_reg)
                begin
                    lo_next = hi_reg;
                    if (hi_reg == n_reg)
                    begin
                        w_next       = {w_reg[CW-1:0], 1'b0};
                        src_sel_next = !src_sel_reg;
                    end
                end
            end
            S_FILL:
            begin
                if (take_r_reg)
                begin
                    head_r_next = rdata;
                end
                else
                begin
                    head_l_next = rdata;
                end
            end
            S_SCAN_RD:
            begin
                rd_addr = k_reg[AW-1:0];
            end
            S_SCAN_ACC:
            begin
                // Each equal neighbor adds the count of earlier items in its run.
                prev_next = rdata;
                k_next    = k_inc;
                if (k_reg != '0)
                begin
                    if (mode_reg)
                    begin
                        if (y_eq)
                        begin
                            run_a_next = run_a_reg + 1'b1;
                            m2_next    = m2_reg + {{CW{1'b0}}, run_a_reg + 1'b1};
                        end
                        else
                        begin
                            run_a_next = '0;
                        end
                    end
                    else
                    begin
                        if (x_eq)
                        begin
                            run_a_next = run_a_reg + 1'b1;
                            m1_next    = m1_reg + {{CW{1'b0}}, run_a_reg + 1'b1};
                        end
                        else
                        begin
                            run_a_next = '0;
                        end
                        if (x_eq && y_eq)
                        begin
                            run_b_next = run_b_reg + 1'b1;
                            m3_next    = m3_reg + {{CW{1'b0}}, run_b_reg + 1'b1};
                        end
                        else
                        begin
                            run_b_next = '0;
                        end
                    end
                end
                if ((k_inc == n_reg) && !mode_reg)
                begin
                    mode_next = 1'b1;
                    w_next    = {{CW{1'b0}}, 1'b1};
                    inv_next  = '0;
                end
            end
            S_MUL1:
            begin
                mul_next = mul_a * mul_b;
            end
            S_SCORE:
            begin
                d1_next = d1_val;
                d2_next = d2_val;
                s_next  = s_val;
                tau_next = '0;
                if ((n_reg < CW'(2)) || (d1_val == '0) || (d2_val == '0))
                begin
                    status_next = ST_UNDEF;
                end
                else
                begin
                    status_next = ST_OK;
                end
            end
            S_MUL2:
            begin
                mul_next = mul_a * mul_b;
            end
            S_MUL3:
            begin
                s2_next  = mul_reg;
                mul_next = mul_a * mul_b;
            end
            S_ROOT_GO:
            begin
                root_start = 1'b1;
            end
            S_ROOT:
            begin
                if (root_res.done)
                begin
                    if (s_reg[SW-1])
                    begin
                        tau_next = '0 - {1'b0, root_res.mag};
                    end
                    else
                    begin
                        tau_next = {1'b0, root_res.mag};
                    end
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {{(M_TDATA_W-TAU_W-SCORE_W-2*UNTIED_W){1'b0}},
                                     d2_ext[UNTIED_W-1:0], d1_ext[UNTIED_W-1:0],
                                     s_ext[SCORE_W-1:0], tau_reg};
                    out_user_next = status_reg;
                end
            end
            default:
            begin
                root_start = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            order_err_reg <= 1'b0;
            ovf_err_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            src_sel_reg   <= 1'b0;
            mode_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            order_err_reg <= order_err_next;
            ovf_err_reg   <= ovf_err_next;
            m_tvalid_reg  <= m_tvalid_next;
            src_sel_reg   <= src_sel_next;
            mode_reg      <= mode_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        last_x_reg   <= last_x_next;
        n_reg        <= n_next;
        w_reg        <= w_next;
        lo_reg       <= lo_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        o_reg        <= o_next;
        head_l_reg   <= head_l_next;
        head_r_reg   <= head_r_next;
        take_r_reg   <= take_r_next;
        inv_reg      <= inv_next;
        k_reg        <= k_next;
        prev_reg     <= prev_next;
        run_a_reg    <= run_a_next;
        run_b_reg    <= run_b_next;
        m1_reg       <= m1_next;
        m2_reg       <= m2_next;
        m3_reg       <= m3_next;
        mul_reg      <= mul_next;
        s2_reg       <= s2_next;
        s_reg        <= s_next;
        d1_reg       <= d1_next;
        d2_reg       <= d2_next;
        status_reg   <= status_next;
        tau_reg      <= tau_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

/* hw/rtl/kt_checker.sv */
// Port-level checks for the Kendall tau-b engine, bound to the top level.
module kt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kt_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [kt_pkg::STATUS_W-1:0]   m_tuser
);
    import kt_pkg::*;

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Error results carry no counts.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_ORDER || m_tuser == ST_OVERFLOW) |-> m_tdata == '0)
        else $error("error result with nonzero fields");

    // An undefined ratio reports tau as zero.
    a_undef_tau: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_UNDEF |-> m_tdata[TAU_W-1:0] == '0)
        else $error("undefined ratio with nonzero tau");

    // Loading continues until the last pair of a set.
    a_keep_loading: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("input stopped inside a set");

    // The set is processed after its last pair.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after the last pair");

endmodule

bind kendall_tau_b_merge_count kt_checker u_kt_checker (.*);

/* test/tb_top.sv */
// Self-checking testbench for the Kendall tau-b merge-count engine.
class tau_scoreboard;
    typedef struct {
        logic [31:0] tau;
        logic [19:0] score;
        logic [18:0] xu;
        logic [18:0] yu;
        kt_pkg::status_t st;
    } tau_result_t;

    logic [31:0] xs[$];
    logic [31:0] ys[$];
    bit order_bad;
    bit ovf_bad;
    tau_result_t pending[$];
    int errors;

    // Largest t in [0, 2^30] with (2t-1)^2 * prod <= s2 * 2^62.
    function automatic logic [31:0] tau_mag(logic [127:0] s2, logic [127:0] prod);
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        logic [127:0] d;
        logic [255:0] lhs;
        logic [255:0] rhs;
        lo = 0;
        hi = 128'h4000_0000;
        rhs = {128'd0, s2} << 62;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            d = 2 * mid - 1;
            lhs = {128'd0, d * d} * {128'd0, prod};
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo[31:0];
    endfunction

    // Pairs tied within sorted runs of equal values.
    function automatic longint run_ties(logic [31:0] a[$]);
        longint sum;
        longint run;
        sum = 0;
        run = 1;
        for (int i = 1; i <= a.size(); i++) begin
            if (i < a.size() && a[i] == a[i-1]) run++;
            else begin
                sum += run * (run - 1) / 2;
                run = 1;
            end
        end
        return sum;
    endfunction

    // Note one accepted pair; at the closing pair compute the expected result.
    function void note_pair(logic [31:0] xk, logic [31:0] yk, bit lst);
        tau_result_t r;
        logic [31:0] xo;
        logic [31:0] yo;
        logic [31:0] grp[$];
        logic [31:0] yg[$];
        logic [31:0] ysorted[$];
        longint n;
        longint m1;
        longint m2;
        longint m3;
        longint inv;
        longint p;
        longint s;
        longint as_;
        int st;
        xo = xk ^ 32'h8000_0000;
        yo = yk ^ 32'h8000_0000;
        if (xs.size() > 0 && xo < xs[$]) order_bad = 1;
        if (xs.size() >= 1024) ovf_bad = 1;
        else begin
            xs.push_back(xo);
            ys.push_back(yo);
        end
        if (!lst) return;
        r.tau = 0; r.score = 0; r.xu = 0; r.yu = 0;
        if (ovf_bad || order_bad) begin
            r.st = ovf_bad ? kt_pkg::ST_OVERFLOW : kt_pkg::ST_ORDER;
        end else begin
            n = xs.size();
            m1 = 0; m3 = 0; st = 0;
            // Sort y inside each run of equal x before counting inversions.
            for (int i = 1; i <= n; i++) begin
                if (i == n || xs[i] != xs[st]) begin
                    grp = ys[st:i-1];
                    grp.sort();
                    m1 += longint'(i - st) * (i - st - 1) / 2;
                    m3 += run_ties(grp);
                    yg = {yg, grp};
                    st = i;
                end
            end
            inv = 0;
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (yg[j] < yg[i]) inv++;
            ysorted = ys;
            ysorted.sort();
            m2 = run_ties(ysorted);
            p = n * (n > 0 ? n - 1 : 0) / 2;
            s = p - m1 - m2 + m3 - 2 * inv;
            r.score = s[19:0];
            r.xu = 19'(p - m1);
            r.yu = 19'(p - m2);
            if (n < 2 || p == m1 || p == m2) r.st = kt_pkg::ST_UNDEF;
            else begin
                r.st = kt_pkg::ST_OK;
                as_ = s < 0 ? -s : s;
                r.tau = tau_mag(128'(as_) * 128'(as_), 128'(p - m1) * 128'(p - m2));
                if (s < 0) r.tau = -r.tau;
            end
        end
        pending.push_back(r);
        xs.delete();
        ys.delete();
        order_bad = 0;
        ovf_bad = 0;
    endfunction

    function void check_result(logic [95:0] d, logic [1:0] u);
        tau_result_t e;
        if (pending.size() == 0) begin
            $error("unexpected result item");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[31:0] !== e.tau) begin
            $error("tau_q30 exp %0h got %0h", e.tau, d[31:0]); errors++;
        end
        if (d[51:32] !== e.score) begin
            $error("score_sum exp %0h got %0h", e.score, d[51:32]); errors++;
        end
        if (d[70:52] !== e.xu) begin
            $error("x_untied_pairs exp %0h got %0h", e.xu, d[70:52]); errors++;
        end
        if (d[89:71] !== e.yu) begin
            $error("y_untied_pairs exp %0h got %0h", e.yu, d[89:71]); errors++;
        end
        if (u !== e.st) begin
            $error("status exp %0d got %0d", e.st, u); errors++;
        end
    endfunction
endclass

module tb_top;
    logic clk = 0;
    logic rst_n = 0;
    logic [63:0] s_tdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic s_tlast = 0;
    logic [95:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tvalid;
    logic m_tready = 0;
    tau_scoreboard sb = new();
    bit hold_off = 0;
    bit no_stall = 0;
    int sent = 0;
    longint cycles = 0;

    kendall_tau_b_merge_count i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk) begin
        cycles++;
        if (cycles > 64'd30_000_000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sample both sides at the rising edge.
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready) sb.note_pair(s_tdata[31:0], s_tdata[63:32], s_tlast);
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // Receiver stall pattern.
    always @(negedge clk) begin
        if (hold_off) m_tready <= 0;
        else if (no_stall) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Send one pair, with an occasional gap in front.
    task automatic send_pair(logic [31:0] xk, logic [31:0] yk, bit lst);
        if ($urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tdata <= {yk, xk};
        s_tlast <= lst;
        s_tvalid <= 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Send a well-formed set of n pairs; small key ranges create ties.
    task automatic send_set(int n, int xr, int yr);
        logic [31:0] x;
        x = -32'(xr);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) x = x + $urandom_range(0, 3);
            send_pair(x, yr == 0 ? $urandom : $urandom_range(0, yr), i == n - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    initial begin
        logic [31:0] x;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // Directed: single pair, extremes, x all tied, y all tied, disorder, full agreement, full reversal.
        send_pair(32'h8000_0000, 32'h7fff_ffff, 1);
        send_pair(32'h8000_0000, 32'h7fff_ffff, 0);
        send_pair(32'h7fff_ffff, 32'h8000_0000, 1);
        send_pair(32'h0, 32'h1, 0);
        send_pair(32'h0, 32'h2, 0);
        send_pair(32'h0, 32'h0, 1);
        send_pair(32'h1, 32'h5, 0);
        send_pair(32'h2, 32'h5, 0);
        send_pair(32'h3, 32'h5, 1);
        send_pair(32'h5, 32'h1, 0);
        send_pair(32'h4, 32'h2, 0);
        send_pair(32'h6, 32'h3, 1);
        send_pair(32'h1, 32'h1, 0);
        send_pair(32'h2, 32'h2, 0);
        send_pair(32'h3, 32'h3, 1);
        send_pair(32'h1, 32'h3, 0);
        send_pair(32'h2, 32'h2, 0);
        send_pair(32'h3, 32'h1, 1);
        drain();
        // Overflow: 1030 pairs in one set, with all-ones and all-zeros y keys.
        x = 32'h8000_0000;
        for (int i = 0; i < 1030; i++)
            send_pair(x + i, i[0] ? 32'hffff_ffff : 32'h0, i == 1029);
        // Large set with many merge passes.
        send_set(512, 8, 0);
        drain();
        // Long receiver hold-off while the sender keeps going.
        hold_off = 1;
        fork
            begin
                repeat (3000) @(negedge clk);
                hold_off = 0;
            end
            begin
                for (int k = 0; k < 6; k++) send_set($urandom_range(2, 10), 4, 3);
            end
        join
        drain();
        // Random sets, mostly small; some broken ones.
        while (sent < 1750) begin
            no_stall = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    send_pair($urandom, $urandom, 0);
                    send_pair($urandom, $urandom, 0);
                    send_pair($urandom, $urandom, 1);
                end
                1: send_set($urandom_range(1, 3), 2, 1);
                2: send_set($urandom_range(20, 60), 1000, 0);
                default: send_set($urandom_range(2, 16), $urandom_range(0, 30),
                                  $urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
            endcase
        end
        no_stall = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/kt_pkg.sv
hw/rtl/kt_ram.sv
hw/rtl/kt_root_div.sv
hw/rtl/kendall_tau_b_merge_count.sv
hw/rtl/kt_checker.sv
test/tb_top.sv
